// ===== hw/rtl/mvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply package
// Shared sizes, request types, command and status codes, and the size clamp.
// ----------------------------------------------------------------------------
package mvm_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int DATA_W   = 16;
	localparam int ACC_W    = 48;
	localparam int PROD_W   = 2 * DATA_W;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int SIZE_W   = 11;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam logic CMD_LOAD     = 1'b0;
	localparam logic CMD_MATRIX   = 1'b1;
	localparam logic STATUS_OK    = 1'b0;
	localparam logic STATUS_EARLY = 1'b1;

	localparam logic [0:0] REG_NUM_COLS = 1'd0;
	localparam logic [0:0] REG_NUM_ROWS = 1'd1;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic                     cmd;
		logic signed [DATA_W-1:0] element_value;
	} item_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] row_sum;
		logic [ROW_W-1:0]        row_number;
		logic                    last_row;
		logic                    status;
	} result_t;

	// Sizes below one act as one, sizes above the maximum act as the maximum.
	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] max_v);
		logic [SIZE_W-1:0] r;
		if (v == '0) begin
			r = SIZE_W'(1);
		end else if (v > max_v) begin
			r = max_v;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ===== hw/rtl/mvm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mvm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/matrix_vector_multiply_top.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply
// Computes y = M*x in signed Q4.12 with a saturating Q24.24 accumulator.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle, with no gaps, for both vector
// loads and matrix elements, unless a result held in the output register
// stalls the pipeline. A vector load writes the vector RAM at once; a matrix
// element reads the vector RAM at its column (one read per cycle on the RAM's
// read port), is multiplied in the next stage and added into the accumulator
// in the stage after that, so a row sum or an error result passes stage 1 and
// stage 2 before it reaches the output register. The accumulator add with its
// saturation is the only loop, so consecutive elements of a row follow back to
// back. While a result waits in the output register, the two pipeline stages
// in front of it still take requests. The vector RAM needs no clearing after
// reset: an entry is only read after the full vector has been loaded.
// Configuration writes are made while the block is idle; a num_cols write
// discards the vector, and any write restarts the matrix at row zero.
// ----------------------------------------------------------------------------
module matrix_vector_multiply_top
	import mvm_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  item_t             item,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	// Configuration and sequencing state.
	logic [SIZE_W-1:0] num_cols_q;
	logic [SIZE_W-1:0] num_rows_q;
	logic [COL_W-1:0]  fill_q;
	logic              ready_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	// Stage 1: vector RAM read in flight.
	logic                     valid_s1;
	logic                     err_s1;
	logic                     first_s1;
	logic                     end_s1;
	logic                     last_s1;
	logic [ROW_W-1:0]         row_s1;
	logic signed [DATA_W-1:0] val_s1;

	// Stage 2: product ready for accumulation.
	logic                     valid_s2;
	logic                     err_s2;
	logic                     first_s2;
	logic                     end_s2;
	logic                     last_s2;
	logic [ROW_W-1:0]         row_s2;
	logic signed [PROD_W-1:0] prod_s2;

	logic signed [ACC_W-1:0] acc_q;
	logic                    out_valid_q;
	result_t                 out_q;

	logic                     cfg_wr;
	logic [0:0]               reg_sel;
	logic [SIZE_W-1:0]        cfg_size;
	logic                     accept;
	logic                     is_load;
	logic                     is_matrix;
	logic [COL_W-1:0]         load_idx;
	logic [SIZE_W-1:0]        load_next;
	logic [SIZE_W-1:0]        col_next;
	logic [SIZE_W-1:0]        row_next;
	logic                     col_end;
	logic                     row_last;
	logic                     out_free;
	logic                     has_res_s2;
	logic                     move_s2;
	logic                     free_s2;
	logic                     free_s1;
	logic [DATA_W-1:0]        ram_rd_data;
	logic signed [PROD_W-1:0] mul;
	logic signed [ACC_W-1:0]  acc_base;
	logic signed [ACC_W:0]    sum_wide;
	logic signed [ACC_W-1:0]  sum_sat;

	// Configuration port. Only the register index bit of the address is decoded.
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && pready;
	assign reg_sel  = paddr[2];
	assign cfg_size = pwdata[SIZE_W-1:0];

	always_comb begin
		case (reg_sel)
			REG_NUM_COLS: prdata = APB_DW'(num_cols_q);
			REG_NUM_ROWS: prdata = APB_DW'(num_rows_q);
			default:      prdata = '0;
		endcase
	end

	// Backpressure runs from the output register back to the request port. An
	// item leaves stage 2 when it makes no result or the output register frees.
	assign out_free   = !out_valid_q || result_ready;
	assign has_res_s2 = err_s2 || end_s2;
	assign move_s2    = valid_s2 && (!has_res_s2 || out_free);
	assign free_s2    = !valid_s2 || move_s2;
	assign free_s1    = !valid_s1 || free_s2;
	assign item_ready = free_s1;

	assign accept    = item_valid && item_ready;
	assign is_load   = accept && (item.cmd == CMD_LOAD);
	assign is_matrix = accept && (item.cmd == CMD_MATRIX);

	// A load while a vector is held starts a new vector at entry zero.
	assign load_idx  = ready_q ? '0 : fill_q;
	assign load_next = SIZE_W'(load_idx) + SIZE_W'(1);
	assign col_next  = SIZE_W'(col_q) + SIZE_W'(1);
	assign row_next  = SIZE_W'(row_q) + SIZE_W'(1);
	assign col_end   = col_next >= num_cols_q;
	assign row_last  = row_next >= num_rows_q;

	mvm_ram #(
		.WIDTH(DATA_W),
		.DEPTH(MAX_COLS)
	) u_vector_ram (
		.clk     (clk),
		.wr_en   (is_load),
		.wr_addr (load_idx),
		.wr_data (item.element_value),
		.rd_en   (is_matrix && ready_q),
		.rd_addr (col_q),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_cols_q <= SIZE_W'(MAX_COLS);
			num_rows_q <= SIZE_W'(MAX_ROWS);
			fill_q     <= '0;
			ready_q    <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (cfg_wr) begin
			col_q <= '0;
			row_q <= '0;
			case (reg_sel)
				REG_NUM_COLS: begin
					num_cols_q <= clamp_size(cfg_size, SIZE_W'(MAX_COLS));
					fill_q     <= '0;
					ready_q    <= 1'b0;
				end
				REG_NUM_ROWS: begin
					num_rows_q <= clamp_size(cfg_size, SIZE_W'(MAX_ROWS));
				end
				default: begin
				end
			endcase
		end else if (is_load) begin
			if (ready_q) begin
				col_q <= '0;
				row_q <= '0;
			end
			if (load_next >= num_cols_q) begin
				fill_q  <= '0;
				ready_q <= 1'b1;
			end else begin
				fill_q  <= load_next[COL_W-1:0];
				ready_q <= 1'b0;
			end
		end else if (is_matrix && ready_q) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_next[ROW_W-1:0];
			end else begin
				col_q <= col_next[COL_W-1:0];
			end
		end
	end

	// Pipeline valid bits. Vector loads finish at the request port and never
	// enter the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free_s1) begin
				valid_s1 <= is_matrix;
			end
			if (free_s2) begin
				valid_s2 <= valid_s1;
			end
			if (move_s2 && has_res_s2) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign mul = val_s1 * $signed(ram_rd_data);

	always_ff @(posedge clk) begin
		if (is_matrix) begin
			err_s1   <= !ready_q;
			first_s1 <= (col_q == '0);
			end_s1   <= ready_q && col_end;
			last_s1  <= row_last;
			row_s1   <= row_q;
			val_s1   <= item.element_value;
		end
		if (valid_s1 && free_s2) begin
			err_s2   <= err_s1;
			first_s2 <= first_s1;
			end_s2   <= end_s1;
			last_s2  <= last_s1;
			row_s2   <= row_s1;
			prod_s2  <= mul;
		end
	end

	// Saturating accumulate. The first column of a row starts from zero, which
	// also drops whatever an abandoned row left behind.
	assign acc_base = first_s2 ? '0 : acc_q;
	assign sum_wide = (ACC_W+1)'(acc_base) + (ACC_W+1)'(prod_s2);

	always_comb begin
		if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
			sum_sat = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
		end else begin
			sum_sat = sum_wide[ACC_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (move_s2 && !err_s2) begin
			acc_q <= sum_sat;
		end
		if (move_s2 && has_res_s2) begin
			out_q.row_number <= row_s2;
			if (err_s2) begin
				out_q.row_sum  <= '0;
				out_q.last_row <= 1'b0;
				out_q.status   <= STATUS_EARLY;
			end else begin
				out_q.row_sum  <= sum_sat;
				out_q.last_row <= last_s2;
				out_q.status   <= STATUS_OK;
			end
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// ===== dv/tb_matrix_vector_multiply_top.sv =====
// ----------------------------------------------------------------------------
// Matrix-vector multiply testbench
// Drives vector loads and matrix elements through the request channel, writes
// the size registers over APB between phases, and checks every result
// against a cycle-free model of the row accumulation kept in the bench.
// ----------------------------------------------------------------------------
module tb_matrix_vector_multiply_top;
	import mvm_pkg::*;

	// Cycles with no handshake on either channel before the run is abandoned.
	// The slowest gaps are geometric runs of sender or receiver stalls plus a
	// short drain before each register write, so this is far beyond any
	// correct run.
	localparam int STALL_LIMIT   = 5000;
	// Cycles allowed for matrix elements still in the pipeline to settle
	// before a register write.
	localparam int DRAIN_CYCLES  = 6;
	localparam int NUM_DIRECTED  = 23;

	typedef enum logic {STEP_REQUEST, STEP_SIZES} step_kind_e;

	// One row of the directed table: either a request, or a pair of size
	// register values. Where typed is set, want is the result the request
	// must give; otherwise the model below decides.
	typedef struct packed {
		step_kind_e        kind;
		item_t             req;
		logic [SIZE_W-1:0] cols_raw;
		logic [SIZE_W-1:0] rows_raw;
		logic              typed;
		result_t           want;
	} directed_step_t;

	// A matrix element taken before the vector is complete is dropped and
	// reported. Row zero is the only row it can report, since every way of
	// emptying the vector also restarts the matrix.
	localparam result_t EARLY_ROW0 = '{row_sum: '0, row_number: '0, last_row: 1'b0,
		status: STATUS_EARLY};
	localparam result_t NO_TYPED = '0;

	logic              clk;
	logic              arst_n;
	logic              item_valid;
	logic              item_ready;
	item_t             item;
	logic              result_valid;
	logic              result_ready;
	result_t           result;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [APB_AW-1:0] paddr;
	logic [APB_DW-1:0] pwdata;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	matrix_vector_multiply_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	// Model state: our own copy of the vector, the fill and walk positions,
	// the running row sum and the sizes in force.
	logic signed [DATA_W-1:0] vector_copy [MAX_COLS];
	int unsigned fill_pos;
	int unsigned col_pos;
	int unsigned row_pos;
	int unsigned cols_in_use;
	int unsigned rows_in_use;
	bit          vector_loaded;
	longint      row_acc;

	// Results the block still owes, oldest first.
	result_t expected_rows [$];

	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned requests_sent;
	int unsigned mismatches;
	int unsigned quiet_cycles;

	// The directed part: corner values of the element, the early-element
	// error right after reset, a 3x2 product and the first row of a second
	// one to show that the row counter wraps into a new matrix, and a reload
	// in the middle of a row that empties the vector and brings the error back.
	directed_step_t directed_steps [NUM_DIRECTED] = '{
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh7FFF}, 11'd0, 11'd0, 1'b1, EARLY_ROW0},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b1, EARLY_ROW0},
		'{STEP_SIZES,   '{CMD_LOAD,   16'sh0000}, 11'd3, 11'd2, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_LOAD,   16'sh7FFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_LOAD,   16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_LOAD,   16'sh0001}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh7FFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'shFFFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh7FFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh0000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh1234}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_LOAD,   16'shFFFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh7FFF}, 11'd0, 11'd0, 1'b1, EARLY_ROW0},
		'{STEP_REQUEST, '{CMD_LOAD,   16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_LOAD,   16'sh7FFF}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED},
		'{STEP_REQUEST, '{CMD_MATRIX, 16'sh8000}, 11'd0, 11'd0, 1'b0, NO_TYPED}
	};

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Advances the model by one accepted request. Returns 1 and fills row
	// when the request closes a row or is an early matrix element.
	function automatic bit accumulate_request(input item_t req, output result_t row);
		longint sum;
		bit     last;
		row = '0;
		if (req.cmd == CMD_LOAD) begin
			// A load after the vector is complete starts a fresh vector and
			// throws away whatever matrix was in progress.
			if (vector_loaded) begin
				vector_loaded = 1'b0;
				fill_pos      = 0;
				col_pos       = 0;
				row_pos       = 0;
				row_acc       = 0;
			end
			vector_copy[fill_pos] = req.element_value;
			fill_pos++;
			if (fill_pos >= cols_in_use) begin
				fill_pos      = 0;
				vector_loaded = 1'b1;
			end
			return 1'b0;
		end
		if (!vector_loaded) begin
			row.row_number = ROW_W'(row_pos);
			row.status     = STATUS_EARLY;
			return 1'b1;
		end
		// Q4.12 times Q4.12 lands in Q8.24; the sum clamps at the accumulator
		// bounds after every element.
		sum = row_acc + longint'(req.element_value) * longint'(vector_copy[col_pos]);
		if (sum > longint'(ACC_MAX)) begin
			sum = longint'(ACC_MAX);
		end else if (sum < longint'(ACC_MIN)) begin
			sum = longint'(ACC_MIN);
		end
		row_acc = sum;
		col_pos++;
		if (col_pos < cols_in_use) begin
			return 1'b0;
		end
		last           = (row_pos + 1 >= rows_in_use);
		row.row_sum    = row_acc[ACC_W-1:0];
		row.row_number = ROW_W'(row_pos);
		row.last_row   = last;
		row.status     = STATUS_OK;
		row_acc        = 0;
		col_pos        = 0;
		row_pos        = last ? 0 : row_pos + 1;
		return 1'b1;
	endfunction

	function automatic logic signed [DATA_W-1:0] random_element();
		case ($urandom_range(7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return '0;
			3: return '1;
			default: return DATA_W'($urandom);
		endcase
	endfunction

	// Presents one request, optionally after a random gap, and holds it until
	// the block takes it. Valid stays high from one request to the next
	// unless a gap is drawn.
	task automatic send_request(input item_t req, input bit typed, input result_t want);
		result_t row;
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		item_valid <= 1'b1;
		item       <= req;
		do @(posedge clk); while (!item_ready);
		requests_sent++;
		if (accumulate_request(req, row) || typed) begin
			expected_rows.push_back(typed ? want : row);
		end
	endtask

	// Lowers valid and waits until every owed result is back, then lets the
	// pipeline run dry, since trailing matrix elements of a row give nothing.
	task automatic drain_block();
		item_valid <= 1'b0;
		while (expected_rows.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One APB write: a setup phase, an access phase, then an idle phase so
	// that back-to-back writes never touch psel twice in one step.
	task automatic write_size(input logic [0:0] index, input logic [SIZE_W-1:0] raw);
		int unsigned sz;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= APB_AW'({index, 2'b00});
		pwdata  <= APB_DW'(raw);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// Zero acts as one and anything past the maximum acts as the maximum.
		// Every write restarts the matrix; a column write also empties the
		// vector.
		if (index == REG_NUM_COLS) begin
			sz            = (raw == 0) ? 1 : (raw > MAX_COLS) ? MAX_COLS : raw;
			cols_in_use   = sz;
			vector_loaded = 1'b0;
			fill_pos      = 0;
		end else begin
			sz          = (raw == 0) ? 1 : (raw > MAX_ROWS) ? MAX_ROWS : raw;
			rows_in_use = sz;
		end
		col_pos = 0;
		row_pos = 0;
		row_acc = 0;
		@(posedge clk);
	endtask

	// Completes the vector if needed, then streams one or two whole matrices.
	// Large sizes get a single pass to keep the run short.
	task automatic stream_product();
		int unsigned passes;
		while (!vector_loaded) begin
			send_request('{cmd: CMD_LOAD, element_value: random_element()}, 1'b0, NO_TYPED);
		end
		passes = (cols_in_use * rows_in_use > 256) ? 1 : $urandom_range(1, 2);
		repeat (passes * cols_in_use * rows_in_use) begin
			send_request('{cmd: CMD_MATRIX, element_value: random_element()}, 1'b0,
				NO_TYPED);
		end
	endtask

	// One phase of random traffic under a new size setting. Most of it is
	// complete products; the rest is loose requests and products cut short
	// by a reload, which drives the early-element error.
	task automatic run_phase(input bit cols_too, input logic [SIZE_W-1:0] cols_raw,
		input logic [SIZE_W-1:0] rows_raw, input int unsigned budget);
		int unsigned start;
		int unsigned pick;
		drain_block();
		if (cols_too) begin
			write_size(REG_NUM_COLS, cols_raw);
		end
		write_size(REG_NUM_ROWS, rows_raw);
		start = requests_sent;
		stream_product();
		while (requests_sent - start < budget) begin
			pick = $urandom_range(99);
			if (pick < 75) begin
				stream_product();
			end else if (pick < 87) begin
				send_request('{cmd: 1'($urandom_range(1)), element_value: random_element()},
					1'b0, NO_TYPED);
			end else begin
				repeat ($urandom_range(0, 2 * cols_in_use)) begin
					send_request('{cmd: CMD_MATRIX, element_value: random_element()}, 1'b0,
						NO_TYPED);
				end
				repeat ($urandom_range(1, cols_in_use)) begin
					send_request('{cmd: CMD_LOAD, element_value: random_element()}, 1'b0,
						NO_TYPED);
				end
				repeat ($urandom_range(1, 2)) begin
					send_request('{cmd: CMD_MATRIX, element_value: random_element()}, 1'b0,
						NO_TYPED);
				end
			end
		end
	endtask

	// Receiver side: draws result_ready every cycle, checks each accepted
	// result against the oldest expectation, and counts cycles in which
	// neither channel moves anything for the watchdog.
	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n) begin
			if ((item_valid && item_ready) || (result_valid && result_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (result_valid && result_ready) begin
				if (expected_rows.size() == 0) begin
					$display("%0t: result with nothing expected, got %h", $time, result);
					mismatches++;
				end else begin
					want = expected_rows.pop_front();
					if (result.row_sum !== want.row_sum) begin
						$display("%0t: row_sum expected %0d, got %0d", $time,
							want.row_sum, result.row_sum);
						mismatches++;
					end
					if (result.row_number !== want.row_number) begin
						$display("%0t: row_number expected %0d, got %0d", $time,
							want.row_number, result.row_number);
						mismatches++;
					end
					if (result.last_row !== want.last_row) begin
						$display("%0t: last_row expected %b, got %b", $time,
							want.last_row, result.last_row);
						mismatches++;
					end
					if (result.status !== want.status) begin
						$display("%0t: status expected %b, got %b", $time,
							want.status, result.status);
						mismatches++;
					end
				end
			end
		end else begin
			quiet_cycles <= 0;
		end
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog: a hang on either channel ends the run as a failure.
	initial begin
		while (quiet_cycles < STALL_LIMIT) @(posedge clk);
		$display("Verification failed");
		$finish;
	end

	initial begin
		// Every input is known from time zero; reset is held from the start and
		// released on a clock edge.
		arst_n        = 1'b0;
		item_valid    = 1'b0;
		item          = '0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		requests_sent = 0;
		fill_pos      = 0;
		col_pos       = 0;
		row_pos       = 0;
		row_acc       = 0;
		vector_loaded = 1'b0;
		cols_in_use   = MAX_COLS;
		rows_in_use   = MAX_ROWS;
		send_idle_pct = 37;
		recv_idle_pct = 86;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table, with the sender sparse and the receiver mostly
		// stalled.
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_SIZES) begin
				drain_block();
				write_size(REG_NUM_COLS, directed_steps[i].cols_raw);
				write_size(REG_NUM_ROWS, directed_steps[i].rows_raw);
			end else begin
				send_request(directed_steps[i].req, directed_steps[i].typed,
					directed_steps[i].want);
			end
		end

		// A small product, then both sizes written as zero so they act as one.
		run_phase(1'b1, 11'd3, 11'd2, 120);
		run_phase(1'b1, 11'd0, 11'd0, 40);

		// Roles swap: the sender mostly stalls and the receiver rarely does.
		// A sixteen-element vector follows the random setting.
		send_idle_pct = 86;
		recv_idle_pct = 37;
		run_phase(1'b1, SIZE_W'($urandom_range(2, 8)), SIZE_W'($urandom_range(2, 6)), 100);
		run_phase(1'b1, 11'd16, 11'd2, 0);

		// No idling on either side: a tall single-column matrix, a rows-only
		// write that keeps the loaded vector, and a last random setting.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(1'b1, 11'd0, 11'd24, 0);
		run_phase(1'b0, 11'd0, 11'd5, 60);
		run_phase(1'b1, SIZE_W'($urandom_range(1, 8)), SIZE_W'($urandom_range(1, 6)), 100);

		// All requests are in; wait for the owed results, then keep the clock
		// running so that a stray extra result would still be caught.
		drain_block();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && expected_rows.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
